/* hdl/irc_pkg.sv */
// Shared types, constants and status codes of the index range coalescer.
`timescale 1ns / 1ps
`default_nettype none
package irc_pkg;

  localparam int MAX_RANGES_DEF = 16;
  localparam int IDX_W          = 31;
  localparam int WORD_W         = 32;
  localparam int RUN_W          = 5;
  localparam int STATUS_W       = 3;
  localparam int RESULT_LIMIT   = 64;
  localparam int NUM_W          = $clog2(RESULT_LIMIT);

  localparam logic [RUN_W-1:0] RUN_RESET = RUN_W'(4);

  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXTEND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WORD    = 3'd4;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  localparam logic [WORD_W-1:0] RUN_MARKER = '1;
  localparam logic [WORD_W-1:0] RUN_STEP   = WORD_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE,
    S_REMOVE,
    S_SHIFT,
    S_ELOAD,
    S_EWORD
  } irc_state_t;

  typedef struct packed {
    logic covered;
    logic above;
    logic below;
    logic lo_lt;
  } irc_cmp_t;

  typedef struct packed {
    logic             we_lo;
    logic             we_hi;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } irc_wr_t;

endpackage
`default_nettype wire

/* hdl/irc_table.sv */
// Range table: low and high bound register file, one write and one read port.
`timescale 1ns / 1ps
`default_nettype none
module irc_table import irc_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int AW         = 4
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    raddr,
  output logic      [IDX_W-1:0] rd_lo,
  output logic      [IDX_W-1:0] rd_hi,
  input  wire logic [AW-1:0]    waddr,
  input  wire irc_wr_t          wr
);

  logic [IDX_W-1:0] lo_mem [MAX_RANGES];
  logic [IDX_W-1:0] hi_mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (wr.we_lo) begin
      lo_mem[waddr] <= wr.lo;
    end
    if (wr.we_hi) begin
      hi_mem[waddr] <= wr.hi;
    end
    rd_lo <= lo_mem[raddr];
    rd_hi <= hi_mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/irc_cmp.sv */
// Shared compare unit: relation of the held index to one stored range.
`timescale 1ns / 1ps
`default_nettype none
module irc_cmp import irc_pkg::*; (
  input  wire logic [IDX_W-1:0] key,
  input  wire logic [IDX_W-1:0] lo,
  input  wire logic [IDX_W-1:0] hi,
  output irc_cmp_t              rel
);

  logic [WORD_W-1:0] key_x;
  logic [WORD_W-1:0] lo_x;
  logic [WORD_W-1:0] hi_x;

  always_comb begin
    key_x       = {1'b0, key};
    lo_x        = {1'b0, lo};
    hi_x        = {1'b0, hi};
    rel.covered = (key >= lo) && (key <= hi);
    rel.above   = (hi_x + WORD_W'(1)) == key_x;
    rel.below   = (key_x + WORD_W'(1)) == lo_x;
    rel.lo_lt   = lo < key;
  end

endmodule
`default_nettype wire

/* hdl/irc_seq.sv */
// Sequencer: add scan, merge, shift and emit walk over the range table.
`timescale 1ns / 1ps
`default_nettype none
module irc_seq import irc_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                action,
  input  wire logic [IDX_W-1:0]    index_value,
  input  wire logic                cfg_wr,
  input  wire logic [RUN_W-1:0]    cfg_data,
  output logic      [AW-1:0]       raddr,
  input  wire logic [IDX_W-1:0]    rd_lo,
  input  wire logic [IDX_W-1:0]    rd_hi,
  output logic      [AW-1:0]       waddr,
  output irc_wr_t                  wr,
  output logic      [IDX_W-1:0]    key,
  input  wire irc_cmp_t            rel,
  output logic                     result,
  output logic      [STATUS_W-1:0] status,
  output logic      [WORD_W-1:0]   word,
  output logic                     empty_list,
  output logic                     last_word
);

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);

  irc_state_t           state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        ptr, ptr_next;
  logic [CW-1:0]        pos, pos_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [NUM_W-1:0]     n, n_next;
  logic [IDX_W-1:0]     cur_lo, cur_lo_next;
  logic [IDX_W-1:0]     cur_hi, cur_hi_next;
  logic [IDX_W-1:0]     v, v_next;
  logic [1:0]           sub, sub_next;
  logic                 short_run, short_run_next;
  logic [RUN_W-1:0]     min_run;
  logic                 result_next;
  logic [STATUS_W-1:0]  status_next;
  logic [WORD_W-1:0]    word_next;
  logic                 empty_list_next;
  logic                 last_word_next;
  logic [CW-1:0]        ptr_p1;
  logic [CW-1:0]        ptr_m1;
  logic [CW-1:0]        rd_ptr;
  logic [WORD_W-1:0]    run_len;
  logic                 run_end;
  logic                 fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      result  <= 1'b0;
      min_run <= RUN_RESET;
    end else begin
      state  <= state_next;
      count  <= count_next;
      result <= result_next;
      if (cfg_wr) begin
        min_run <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pos        <= pos_next;
    idx        <= idx_next;
    n          <= n_next;
    cur_lo     <= cur_lo_next;
    cur_hi     <= cur_hi_next;
    v          <= v_next;
    sub        <= sub_next;
    short_run  <= short_run_next;
    status     <= status_next;
    word       <= word_next;
    empty_list <= empty_list_next;
    last_word  <= last_word_next;
  end

  assign busy   = state != S_IDLE;
  assign key    = idx;
  assign ptr_p1 = ptr + CW'(1);
  assign ptr_m1 = ptr - CW'(1);

  // fetch the entry that the next state compares against
  always_comb begin
    unique case (state_next)
      S_MERGE, S_REMOVE: rd_ptr = ptr_next + CW'(1);
      S_SHIFT:           rd_ptr = ptr_next - CW'(1);
      default:           rd_ptr = ptr_next;
    endcase
  end

  assign raddr = rd_ptr[AW-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    pos_next        = pos;
    idx_next        = idx;
    n_next          = n;
    cur_lo_next     = cur_lo;
    cur_hi_next     = cur_hi;
    v_next          = v;
    sub_next        = sub;
    short_run_next  = short_run;
    result_next     = 1'b0;
    status_next     = status;
    word_next       = word;
    empty_list_next = empty_list;
    last_word_next  = last_word;
    waddr           = ptr[AW-1:0];
    wr              = '0;
    run_len         = {1'b0, rd_hi} - {1'b0, rd_lo} + WORD_W'(1);
    run_end         = 1'b0;
    fin             = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          idx_next = index_value;
          ptr_next = '0;
          pos_next = count;
          n_next   = '0;
          if (action == ACT_ADD) begin
            state_next = S_SCAN;
          end else if (count == '0) begin
            result_next     = 1'b1;
            status_next     = ST_WORD;
            word_next       = '0;
            empty_list_next = 1'b1;
            last_word_next  = 1'b1;
          end else begin
            state_next = S_ELOAD;
          end
        end
      end

      S_SCAN: begin
        if (ptr == count) begin
          if (count == CNT_MAX) begin
            result_next     = 1'b1;
            status_next     = ST_FULL;
            word_next       = '0;
            empty_list_next = 1'b0;
            last_word_next  = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (rel.covered) begin
          result_next     = 1'b1;
          status_next     = ST_PRESENT;
          word_next       = '0;
          empty_list_next = 1'b0;
          last_word_next  = 1'b1;
          state_next      = S_IDLE;
        end else if (rel.above) begin
          wr.we_hi   = 1'b1;
          wr.hi      = idx;
          state_next = S_MERGE;
        end else if (rel.below) begin
          wr.we_lo        = 1'b1;
          wr.lo           = idx;
          result_next     = 1'b1;
          status_next     = ST_EXTEND;
          word_next       = '0;
          empty_list_next = 1'b0;
          last_word_next  = 1'b1;
          state_next      = S_IDLE;
        end else begin
          if (pos == count && !rel.lo_lt) begin
            pos_next = ptr;
          end
          ptr_next = ptr_p1;
        end
      end

      S_MERGE: begin
        if (ptr_p1 < count && rel.below) begin
          wr.we_hi   = 1'b1;
          wr.hi      = rd_hi;
          ptr_next   = ptr_p1;
          state_next = S_REMOVE;
        end else begin
          result_next     = 1'b1;
          status_next     = ST_EXTEND;
          word_next       = '0;
          empty_list_next = 1'b0;
          last_word_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_REMOVE: begin
        if (ptr_p1 < count) begin
          wr.we_lo = 1'b1;
          wr.we_hi = 1'b1;
          wr.lo    = rd_lo;
          wr.hi    = rd_hi;
          ptr_next = ptr_p1;
        end else begin
          count_next      = count - CW'(1);
          result_next     = 1'b1;
          status_next     = ST_EXTEND;
          word_next       = '0;
          empty_list_next = 1'b0;
          last_word_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_SHIFT: begin
        wr.we_lo = 1'b1;
        wr.we_hi = 1'b1;
        if (ptr > pos) begin
          wr.lo    = rd_lo;
          wr.hi    = rd_hi;
          ptr_next = ptr_m1;
        end else begin
          waddr           = pos[AW-1:0];
          wr.lo           = idx;
          wr.hi           = idx;
          count_next      = count + CW'(1);
          result_next     = 1'b1;
          status_next     = ST_NEW;
          word_next       = '0;
          empty_list_next = 1'b0;
          last_word_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_ELOAD: begin
        cur_lo_next    = rd_lo;
        cur_hi_next    = rd_hi;
        v_next         = rd_lo;
        sub_next       = '0;
        short_run_next = run_len < WORD_W'(min_run);
        state_next     = S_EWORD;
      end

      S_EWORD: begin
        if (short_run) begin
          word_next = {1'b0, v};
          run_end   = v == cur_hi;
        end else begin
          unique case (sub)
            2'd0: word_next = RUN_MARKER;
            2'd1: word_next = {1'b0, cur_lo};
            2'd2: word_next = {1'b0, cur_hi};
            2'd3: word_next = RUN_STEP;
          endcase
          run_end = sub == 2'd3;
        end
        fin             = (run_end && ptr_p1 == count) || n == NUM_W'(RESULT_LIMIT - 1);
        result_next     = 1'b1;
        status_next     = ST_WORD;
        empty_list_next = 1'b0;
        last_word_next  = fin;
        n_next          = n + NUM_W'(1);
        v_next          = v + IDX_W'(1);
        sub_next        = sub + 2'd1;
        if (fin) begin
          state_next = S_IDLE;
        end else if (run_end) begin
          ptr_next   = ptr_p1;
          state_next = S_ELOAD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/index_range_coalescer.sv */
// Top level of the index range coalescer: table, compare unit and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to MAX_RANGES sorted, disjoint index ranges. Raise start with
// action and index_value while busy is low; busy stays high until the item
// is done and drops in the cycle the last result shows. Every result is on
// the result ports for exactly one cycle with result high and cannot be
// stalled. An add gives one result after a scan of the table, one entry a
// cycle, plus a shift or merge pass over the entries behind the hit. An
// emit gives one word a cycle, paused by a load step per range, at most 64
// words. The range table's single read and write port sets this pace. The
// user must write the run threshold through cfg_valid / cfg_ready only
// while the block is idle; the block itself does not enforce this.
module index_range_coalescer import irc_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       action,
  input  wire logic        [IDX_W-1:0]    index_value,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic        [RUN_W-1:0]    cfg_data,
  output logic                            result,
  output logic             [STATUS_W-1:0] status,
  output logic signed      [WORD_W-1:0]   word,
  output logic                            empty_list,
  output logic                            last_word
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [IDX_W-1:0]  rd_lo;
  logic [IDX_W-1:0]  rd_hi;
  logic [IDX_W-1:0]  key;
  logic [WORD_W-1:0] word_bits;
  irc_wr_t           wr;
  irc_cmp_t          rel;

  assign cfg_ready = 1'b1;
  assign word      = signed'(word_bits);

  irc_table #(
    .MAX_RANGES (MAX_RANGES),
    .AW         (AW)
  ) u_table (
    .clk   (clk),
    .raddr (raddr),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi),
    .waddr (waddr),
    .wr    (wr)
  );

  irc_cmp u_cmp (
    .key (key),
    .lo  (rd_lo),
    .hi  (rd_hi),
    .rel (rel)
  );

  irc_seq #(
    .MAX_RANGES (MAX_RANGES),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .index_value (index_value),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .raddr       (raddr),
    .rd_lo       (rd_lo),
    .rd_hi       (rd_hi),
    .waddr       (waddr),
    .wr          (wr),
    .key         (key),
    .rel         (rel),
    .result      (result),
    .status      (status),
    .word        (word_bits),
    .empty_list  (empty_list),
    .last_word   (last_word)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_index_range_coalescer.sv */
// Self-checking testbench of the index range coalescer, with a range table predictor.
`timescale 1ns / 1ps
module tb_index_range_coalescer;
  import irc_pkg::*;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;
  localparam int PHASE_ITEMS = 41;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word;
    logic                empty;
    logic                last;
  } coalesced_word_t;

  class range_table_model;
    logic [IDX_W-1:0] lo_tab [MAX_RANGES_DEF];
    logic [IDX_W-1:0] hi_tab [MAX_RANGES_DEF];
    int               n_ranges;
    logic [RUN_W-1:0] run_len;
    coalesced_word_t  expected_words [$];
    int               errors;

    function new();
      n_ranges = 0;
      run_len  = RUN_RESET;
      errors   = 0;
    endfunction

    function void push_word(logic [STATUS_W-1:0] st, logic [WORD_W-1:0] w, logic em,
                            logic lw);
      coalesced_word_t e;
      e.status = st;
      e.word   = w;
      e.empty  = em;
      e.last   = lw;
      expected_words.push_back(e);
    endfunction

    function void merge_ranges();
      int i;
      i = 0;
      while (i + 1 < n_ranges) begin
        if ({1'b0, hi_tab[i]} + 1 == {1'b0, lo_tab[i+1]}) begin
          hi_tab[i] = hi_tab[i+1];
          for (int j = i + 1; j + 1 < n_ranges; j++) begin
            lo_tab[j] = lo_tab[j+1];
            hi_tab[j] = hi_tab[j+1];
          end
          n_ranges--;
        end
        i++;
      end
    endfunction

    function logic [STATUS_W-1:0] add_index(logic [IDX_W-1:0] idx);
      logic [WORD_W-1:0] x;
      int pos;
      x = {1'b0, idx};
      for (int i = 0; i < n_ranges; i++) begin
        if (idx >= lo_tab[i] && idx <= hi_tab[i]) return ST_PRESENT;
        if ({1'b0, hi_tab[i]} + 1 == x) begin
          hi_tab[i] = idx;
          merge_ranges();
          return ST_EXTEND;
        end
        if (x + 1 == {1'b0, lo_tab[i]}) begin
          lo_tab[i] = idx;
          merge_ranges();
          return ST_EXTEND;
        end
      end
      if (n_ranges >= MAX_RANGES_DEF) return ST_FULL;
      pos = 0;
      while (pos < n_ranges && lo_tab[pos] < idx) pos++;
      for (int i = n_ranges; i > pos; i--) begin
        lo_tab[i] = lo_tab[i-1];
        hi_tab[i] = hi_tab[i-1];
      end
      lo_tab[pos] = idx;
      hi_tab[pos] = idx;
      n_ranges++;
      return ST_NEW;
    endfunction

    function void emit_list();
      logic [WORD_W-1:0] words [$];
      logic [WORD_W-1:0] span;
      logic [IDX_W-1:0]  v;
      if (n_ranges == 0) begin
        push_word(ST_WORD, '0, 1'b1, 1'b1);
        return;
      end
      for (int i = 0; i < n_ranges && words.size() < RESULT_LIMIT; i++) begin
        span = {1'b0, hi_tab[i]} - {1'b0, lo_tab[i]} + 1;
        if (span < run_len) begin
          v = lo_tab[i];
          while (words.size() < RESULT_LIMIT) begin
            words.push_back({1'b0, v});
            if (v == hi_tab[i]) break;
            v++;
          end
        end else begin
          if (words.size() < RESULT_LIMIT) words.push_back(RUN_MARKER);
          if (words.size() < RESULT_LIMIT) words.push_back({1'b0, lo_tab[i]});
          if (words.size() < RESULT_LIMIT) words.push_back({1'b0, hi_tab[i]});
          if (words.size() < RESULT_LIMIT) words.push_back(RUN_STEP);
        end
      end
      for (int k = 0; k < words.size(); k++)
        push_word(ST_WORD, words[k], 1'b0, k == words.size() - 1);
    endfunction

    function void note_command(logic act, logic [IDX_W-1:0] idx);
      if (act == ACT_ADD) push_word(add_index(idx), '0, 1'b0, 1'b1);
      else emit_list();
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [WORD_W-1:0] w, logic em,
                               logic lw);
      coalesced_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result, status %0d word %0d", $time, st, $signed(w));
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (w !== e.word) begin
        $display("%0t: word expected %0d actual %0d", $time, $signed(e.word), $signed(w));
        errors++;
      end
      if (em !== e.empty) begin
        $display("%0t: empty_list expected %0b actual %0b", $time, e.empty, em);
        errors++;
      end
      if (lw !== e.last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, e.last, lw);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       action;
  logic        [IDX_W-1:0]    index_value;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic        [RUN_W-1:0]    cfg_data;
  logic                       result;
  logic        [STATUS_W-1:0] status;
  logic signed [WORD_W-1:0]   word;
  logic                       empty_list;
  logic                       last_word;

  range_table_model ranges = new();

  index_range_coalescer i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .index_value (index_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .result      (result),
    .status      (status),
    .word        (word),
    .empty_list  (empty_list),
    .last_word   (last_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result) ranges.check_result(status, word, empty_list, last_word);
  end

  task automatic send_command(input logic act, input logic [IDX_W-1:0] idx);
    start       <= 1'b1;
    action      <= act;
    index_value <= idx;
    do @(posedge clk); while (busy);
    ranges.note_command(act, idx);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (ranges.expected_words.size() != 0 || busy);
  endtask

  task automatic write_run_length(input logic [RUN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ranges.run_len = v;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] base);
    int               mode;
    int               r;
    int               off;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    mode = $urandom_range(0, 99);
    if (ranges.n_ranges == 0 && mode < 55) mode = 60;
    if (mode < 55) begin
      r  = $urandom_range(0, ranges.n_ranges - 1);
      lo = ranges.lo_tab[r];
      hi = ranges.hi_tab[r];
    end
    if (mode < 40) begin
      if (hi != IDX_MAX && (lo == '0 || $urandom_range(0, 1) == 0)) return hi + 1'b1;
      return lo - 1'b1;
    end
    if (mode < 55) return lo + IDX_W'($urandom_range(0, hi - lo));
    if (mode < 85) begin
      off = $urandom_range(0, 100);
      return (base > IDX_MAX - off) ? IDX_MAX : base + IDX_W'(off);
    end
    return IDX_W'($urandom);
  endfunction

  initial begin
    int               run_plan [7];
    int               burst;
    int               sent;
    logic             act;
    logic [IDX_W-1:0] base;
    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= ACT_ADD;
    index_value <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(ACT_EMIT, IDX_MAX);
    send_command(ACT_ADD, '0);
    send_command(ACT_ADD, IDX_MAX);
    send_command(ACT_ADD, IDX_MAX - 1'b1);
    send_command(ACT_ADD, IDX_MAX);
    send_command(ACT_ADD, IDX_W'(1));
    send_command(ACT_ADD, IDX_W'(3));
    send_command(ACT_ADD, IDX_W'(2));
    send_command(ACT_EMIT, '0);
    for (int k = 1; k <= 14; k++) send_command(ACT_ADD, IDX_W'(10 * k));
    send_command(ACT_ADD, IDX_W'(1000));
    send_command(ACT_EMIT, '0);

    run_plan = '{1, 0, 16, 31, 2, 4, 0};
    run_plan[6] = $urandom_range(0, 31);
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      write_run_length(RUN_W'(run_plan[ph]));
      base = ($urandom_range(0, 3) == 0) ? IDX_MAX - IDX_W'(100)
                                         : IDX_W'($urandom_range(0, 300));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          act = ($urandom_range(0, 99) < 15) ? ACT_EMIT : ACT_ADD;
          send_command(act, (act == ACT_EMIT) ? IDX_W'($urandom) : pick_index(base));
          sent++;
        end
        // hold off until the block has drained, now and then
        if ($urandom_range(0, 7) == 0) wait_drained();
        else if (ph != 5) idle_for($urandom_range(0, 5));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (ranges.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
hdl/irc_pkg.sv
hdl/irc_table.sv
hdl/irc_cmp.sv
hdl/irc_seq.sv
hdl/index_range_coalescer.sv
tb/sv/tb_index_range_coalescer.sv
